// ===== src/utf8_stream_decoder_assert.svh =====
// Assertion macros for the UTF-8 stream decoder.
// Used by u8sd_core under src; no other dependencies.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, reset-qualified
`define U8SD_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("u8sd assertion failed");

// next-cycle implication, reset-qualified
`define U8SD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("u8sd assertion failed");

`endif

// ===== src/u8sd_pkg.sv =====
// Types, constants and lead-byte functions for the UTF-8 stream decoder.
// No dependencies; imported by every decoder module.
`default_nettype none

package u8sd_pkg;

    localparam int CP_W = 31;
    localparam int LEN_W = 3;
    localparam int OUT_DATA_W = 40;

    localparam logic [7:0] LEAD_MIN_TWO = 8'hC2;
    localparam logic [7:0] INVALID_LEAD = 8'hFE;
    localparam logic [7:0] OVERLONG_TAG = 8'h80;
    localparam logic [1:0] CONT_TAG = 2'b10;
    localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO = 3'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } item_t;

    typedef struct packed {
        logic              truncated;
        logic              well_formed;
        logic [LEN_W-1:0]  char_length;
        logic [CP_W-1:0]   code_point;
    } result_t;

    typedef struct packed {
        logic    load;
        result_t res;
    } core_out_t;

    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        begin
            len = 3'd1;
            if (b[7] == 1'b0)
                len = 3'd1;
            else if (b[7:5] == 3'b110)
                len = 3'd2;
            else if (b[7:4] == 4'b1110)
                len = 3'd3;
            else if (b[7:3] == 5'b11110)
                len = 3'd4;
            else if (b[7:2] == 6'b111110)
                len = 3'd5;
            else if (b[7:1] == 7'b1111110)
                len = 3'd6;
            return len;
        end
    endfunction

    function automatic logic [7:0] overlong_mask(input logic [LEN_W-1:0] len);
        logic [7:0] m;
        begin
            case (len)
                3'd3:    m = 8'hE0;
                3'd4:    m = 8'hF0;
                3'd5:    m = 8'hF8;
                3'd6:    m = 8'hFC;
                default: m = 8'h00;
            endcase
            return m;
        end
    endfunction

    function automatic logic [7:0] payload_mask(input logic [LEN_W-1:0] len);
        logic [7:0] m;
        begin
            case (len)
                3'd2:    m = 8'h1F;
                3'd3:    m = 8'h0F;
                3'd4:    m = 8'h07;
                3'd5:    m = 8'h03;
                3'd6:    m = 8'h01;
                default: m = 8'h3F;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/u8sd_in_reg.sv =====
// Input register stage of the UTF-8 stream decoder.
// Depends on u8sd_pkg.
`default_nettype none

module u8sd_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire u8sd_pkg::item_t s_item,
    input  wire logic           advance,
    output logic                item_valid,
    output u8sd_pkg::item_t     item
);
    import u8sd_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_tready)
            valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= s_item;
    end

endmodule

`default_nettype wire

// ===== src/u8sd_core.sv =====
// Character state and single-pass decode logic of the UTF-8 stream decoder.
// Depends on u8sd_pkg and utf8_stream_decoder_assert.svh.
`default_nettype none
`include "utf8_stream_decoder_assert.svh"

module u8sd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            decode_en,
    input  wire logic            item_valid,
    input  wire u8sd_pkg::item_t item,
    input  wire logic            out_ready,
    output logic                 advance,
    output u8sd_pkg::core_out_t  core_out
);
    import u8sd_pkg::*;

    logic [LEN_W-1:0] exp_len_reg, exp_len_next;
    logic [LEN_W-1:0] seen_reg, seen_next;
    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [7:0]       lmask_reg, lmask_next;
    logic             valid_ch_reg, valid_ch_next;

    logic [7:0]       b;
    logic             eob;
    logic [LEN_W-1:0] len;
    logic [7:0]       omask;
    logic [LEN_W-1:0] seen_inc;
    logic [CP_W-1:0]  acc_shift;
    logic             cont_ok;
    result_t          res;
    logic             emit;

    assign advance  = item_valid && out_ready;
    assign b        = item.data_byte;
    assign eob      = item.end_of_buffer;
    assign len      = lead_length(b);
    assign omask    = overlong_mask(len);
    assign seen_inc = seen_reg + 3'd1;
    assign acc_shift = {acc_reg[CP_W-7:0], b[5:0]};
    assign cont_ok  = valid_ch_reg && (b[7:6] == CONT_TAG) &&
                      !(seen_reg == LEN_ONE && lmask_reg != 8'h00 &&
                        (b & lmask_reg) == OVERLONG_TAG);

    always_comb
    begin
        exp_len_next  = exp_len_reg;
        seen_next     = seen_reg;
        acc_next      = acc_reg;
        lmask_next    = lmask_reg;
        valid_ch_next = valid_ch_reg;
        emit          = 1'b0;
        res.code_point  = {{(CP_W-8){1'b0}}, b};
        res.char_length = LEN_ONE;
        res.well_formed = 1'b1;
        res.truncated   = 1'b0;

        if (!decode_en)
        begin
            emit          = 1'b1;
            exp_len_next  = '0;
            seen_next     = '0;
            acc_next      = '0;
            lmask_next    = '0;
            valid_ch_next = 1'b1;
        end
        else if (exp_len_reg == '0)
        begin
            if (len == LEN_ONE)
            begin
                emit            = 1'b1;
                res.well_formed = (b < INVALID_LEAD);
            end
            else if (eob)
            begin
                emit            = 1'b1;
                res.code_point  = '0;
                res.char_length = len;
                res.well_formed = 1'b0;
                res.truncated   = 1'b1;
            end
            else
            begin
                exp_len_next  = len;
                seen_next     = LEN_ONE;
                acc_next      = {{(CP_W-8){1'b0}}, b & payload_mask(len)};
                valid_ch_next = !(len == LEN_TWO && b < LEAD_MIN_TWO);
                lmask_next    = (len != LEN_TWO && b == omask) ? omask : 8'h00;
            end
        end
        else
        begin
            if (seen_inc >= exp_len_reg)
            begin
                emit            = 1'b1;
                res.code_point  = acc_shift;
                res.char_length = exp_len_reg;
                res.well_formed = cont_ok;
            end
            else if (eob)
            begin
                emit            = 1'b1;
                res.code_point  = '0;
                res.char_length = exp_len_reg;
                res.well_formed = 1'b0;
                res.truncated   = 1'b1;
            end

            if (emit)
            begin
                exp_len_next  = '0;
                seen_next     = '0;
                acc_next      = '0;
                lmask_next    = '0;
                valid_ch_next = 1'b1;
            end
            else
            begin
                seen_next     = seen_inc;
                acc_next      = acc_shift;
                valid_ch_next = cont_ok;
            end
        end
    end

    assign core_out.load = advance && emit;
    assign core_out.res  = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg  <= '0;
            seen_reg     <= '0;
            acc_reg      <= '0;
            lmask_reg    <= '0;
            valid_ch_reg <= 1'b1;
        end
        else if (advance)
        begin
            exp_len_reg  <= exp_len_next;
            seen_reg     <= seen_next;
            acc_reg      <= acc_next;
            lmask_reg    <= lmask_next;
            valid_ch_reg <= valid_ch_next;
        end
    end

    `U8SD_ASSERT_NOW(a_seen_in_range, clk, rst_n, exp_len_reg != '0, seen_reg != '0 && seen_reg < exp_len_reg)
    `U8SD_ASSERT_NOW(a_trunc_zero, clk, rst_n, core_out.load && res.truncated, res.code_point == '0 && !res.well_formed)
    `U8SD_ASSERT_NEXT(a_bypass_clears, clk, rst_n, advance && !decode_en, exp_len_reg == '0)
    `U8SD_ASSERT_NOW(a_idle_clean, clk, rst_n, exp_len_reg == '0, seen_reg == '0 && lmask_reg == 8'h00)

endmodule

`default_nettype wire

// ===== src/u8sd_out_reg.sv =====
// Result register stage of the UTF-8 stream decoder.
// Depends on u8sd_pkg.
`default_nettype none

module u8sd_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire u8sd_pkg::core_out_t core_out,
    output logic                     out_ready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output u8sd_pkg::result_t        m_res
);
    import u8sd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_res     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (core_out.load)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_out.load)
            res_reg <= core_out.res;
    end

endmodule

`default_nettype wire

// ===== src/utf8_stream_decoder.sv =====
// Channel   Dir  Payload
// s_*       in   tdata[7:0] data_byte, tlast end_of_buffer
// m_*       out  tdata[30:0] code_point, [33:31] char_length, [34] well_formed,
//                [35] truncated, [39:36] zero
// cfg_*     in   cfg_wdata decode enable, written when cfg_wen is high
//
// One byte per clock sustained while m_tready is not stalled; an accepted beat is
// held in the input register, then decoded into the result register and sent on m_*.
// A multi-byte character yields one result beat on its last byte.
// Reset clears the character state and sets the decode enable to 1.
// A stalled m_tready holds the result and backs pressure up through both registers.
//
// Top level of the UTF-8 stream decoder; depends on u8sd_pkg, u8sd_in_reg,
// u8sd_core and u8sd_out_reg.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_buffer
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [30:0] code_point, [33:31] char_length,
                                        // [34] well_formed, [35] truncated
    input  wire logic        cfg_wen,
    input  wire logic        cfg_wdata  // decode enable
);
    import u8sd_pkg::*;

    logic      decode_en_reg;
    item_t     s_item;
    item_t     item;
    logic      item_valid;
    logic      advance;
    logic      out_ready;
    core_out_t core_out;
    result_t   m_res;

    assign s_item.data_byte     = s_tdata;
    assign s_item.end_of_buffer = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decode_en_reg <= 1'b1;
        else if (cfg_wen)
            decode_en_reg <= cfg_wdata;
    end

    u8sd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    u8sd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .decode_en  (decode_en_reg),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .advance    (advance),
        .core_out   (core_out)
    );

    u8sd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .core_out   (core_out),
        .out_ready  (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (m_res)
    );

    assign m_tdata = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, m_res};

endmodule

`default_nettype wire
